@@ hdl/assert_macros.svh @@
// Assertion macros used by the kinematics chain back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during rst.
`define ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk and held off during rst.
`define ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/dhfk_pkg.sv @@
// Types, constants and arithmetic helpers for the kinematics chain unit.
`default_nettype none
package dhfk_pkg;

  localparam int WORD_W = 32;

  localparam logic [1:0] KIND_FIXED     = 2'd0;
  localparam logic [1:0] KIND_ROTARY    = 2'd1;
  localparam logic [1:0] KIND_PRISMATIC = 2'd2;

  localparam logic signed [33:0] TWO_PI_Q28  = 34'sd1686629713;
  localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
  localparam logic signed [31:0] ONE_Q30     = 32'sh4000_0000;
  localparam logic [3:0]         SERIES_TERMS = 4'd10;

  localparam logic signed [37:0] WORD_MAX = 38'sd2147483647;
  localparam logic signed [37:0] WORD_MIN = -38'sd2147483648;

  typedef struct packed {
    logic              first_link;
    logic [1:0]        joint_kind;
    logic signed [31:0] link_length;
    logic signed [31:0] link_twist;
    logic signed [31:0] link_offset;
    logic signed [31:0] base_angle;
    logic signed [31:0] joint_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] rot_00;
    logic signed [31:0] rot_01;
    logic signed [31:0] rot_02;
    logic signed [31:0] trans_x;
    logic signed [31:0] rot_10;
    logic signed [31:0] rot_11;
    logic signed [31:0] rot_12;
    logic signed [31:0] trans_y;
    logic signed [31:0] rot_20;
    logic signed [31:0] rot_21;
    logic signed [31:0] rot_22;
    logic signed [31:0] trans_z;
  } out_t;

  typedef struct packed {
    logic              first_link;
    logic signed [31:0] link_length;
    logic signed [31:0] link_twist;
    logic signed [32:0] link_offset;
    logic signed [32:0] joint_angle;
  } work_t;

  function automatic logic signed [35:0] round_q30(input logic signed [65:0] p);
    logic [65:0] mag;
    logic [65:0] sh;
    mag = p[65] ? 66'(-p) : 66'(p);
    sh = (mag + (66'd1 << 29)) >> 30;
    return p[65] ? -$signed(sh[35:0]) : $signed(sh[35:0]);
  endfunction

  function automatic logic signed [31:0] sat_word(input logic signed [37:0] v);
    if (v > WORD_MAX) begin
      return 32'sh7FFF_FFFF;
    end else if (v < WORD_MIN) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

@@ hdl/dhfk_front.sv @@
// Front end: accepts links, folds in the joint value and queues them.
`default_nettype none
module dhfk_front (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  output logic            full,
  input  dhfk_pkg::in_t   link_item,
  output logic            q_valid,
  input  wire             q_take,
  output dhfk_pkg::work_t q_item
);
  import dhfk_pkg::*;

  work_t       ent [0:1];
  logic        wp;
  logic        rp;
  logic [1:0]  cnt;
  work_t       w;
  logic        do_push;
  logic        do_pop;

  always_comb begin
    w.first_link  = link_item.first_link;
    w.link_length = link_item.link_length;
    w.link_twist  = link_item.link_twist;
    w.link_offset = 33'(link_item.link_offset);
    w.joint_angle = 33'(link_item.base_angle);
    case (link_item.joint_kind)
      KIND_ROTARY: begin
        w.joint_angle = 33'(link_item.base_angle) + 33'(link_item.joint_value);
      end
      KIND_PRISMATIC: begin
        w.link_offset = 33'(link_item.link_offset) + 33'(link_item.joint_value);
      end
      default: begin
      end
    endcase
  end

  assign full    = (cnt == 2'd2);
  assign q_valid = (cnt != 2'd0);
  assign q_item  = ent[rp];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        ent[wp] <= w;
        wp      <= !wp;
      end
      if (do_pop) begin
        rp <= !rp;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/dhfk_trig.sv @@
// Iterative sine and cosine unit: range reduction, quadrant split, series.
`default_nettype none
module dhfk_trig (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  wire signed [32:0] angle,
  output logic              done,
  output logic signed [31:0] sin_val,
  output logic signed [31:0] cos_val
);
  import dhfk_pkg::*;

  localparam logic [3:0] T_IDLE = 4'd0;
  localparam logic [3:0] T_RED  = 4'd1;
  localparam logic [3:0] T_QUAD = 4'd2;
  localparam logic [3:0] T_SQM  = 4'd3;
  localparam logic [3:0] T_SQR  = 4'd4;
  localparam logic [3:0] T_MUL  = 4'd5;
  localparam logic [3:0] T_RND  = 4'd6;
  localparam logic [3:0] T_DIV  = 4'd7;
  localparam logic [3:0] T_UPD  = 4'd8;
  localparam logic [3:0] T_QUO  = 4'd9;

  localparam logic [43:0] RECIP_BASE = 44'h800_0000_0000;

  logic [3:0]         state;
  logic signed [33:0] r;
  logic [2:0]         q;
  logic [30:0]        x;
  logic [31:0]        x2;
  logic [31:0]        term;
  logic signed [34:0] sum;
  logic               sel;
  logic [3:0]         k;
  logic [63:0]        prod;
  logic [33:0]        div_n;
  logic [54:0]        p_lo;
  logic [55:0]        p_hi;
  logic [31:0]        div_q;
  logic [30:0]        s_val;

  logic [4:0]         m;
  logic [8:0]         den;
  logic [42:0]        recip;
  logic [63:0]        rsum;
  logic [56:0]        q_sum;
  logic signed [34:0] sum_new;
  logic [30:0]        clamp;
  logic signed [31:0] sp;
  logic signed [31:0] cp;

  always_comb begin
    m    = {k, 1'b0} - 5'(sel);
    den  = 9'(10'(m) * 10'(m + 5'd1));
    rsum = prod + (64'd1 << 29);
    // The quotient is floor(n * ceil(2^43 / den) / 2^43), exact for n below 2^34.
    case (m)
      5'd1:    recip = 43'((RECIP_BASE + 44'd1) / 44'd2);
      5'd2:    recip = 43'((RECIP_BASE + 44'd5) / 44'd6);
      5'd3:    recip = 43'((RECIP_BASE + 44'd11) / 44'd12);
      5'd4:    recip = 43'((RECIP_BASE + 44'd19) / 44'd20);
      5'd5:    recip = 43'((RECIP_BASE + 44'd29) / 44'd30);
      5'd6:    recip = 43'((RECIP_BASE + 44'd41) / 44'd42);
      5'd7:    recip = 43'((RECIP_BASE + 44'd55) / 44'd56);
      5'd8:    recip = 43'((RECIP_BASE + 44'd71) / 44'd72);
      5'd9:    recip = 43'((RECIP_BASE + 44'd89) / 44'd90);
      5'd10:   recip = 43'((RECIP_BASE + 44'd109) / 44'd110);
      5'd11:   recip = 43'((RECIP_BASE + 44'd131) / 44'd132);
      5'd12:   recip = 43'((RECIP_BASE + 44'd155) / 44'd156);
      5'd13:   recip = 43'((RECIP_BASE + 44'd181) / 44'd182);
      5'd14:   recip = 43'((RECIP_BASE + 44'd209) / 44'd210);
      5'd15:   recip = 43'((RECIP_BASE + 44'd239) / 44'd240);
      5'd16:   recip = 43'((RECIP_BASE + 44'd271) / 44'd272);
      5'd17:   recip = 43'((RECIP_BASE + 44'd305) / 44'd306);
      5'd18:   recip = 43'((RECIP_BASE + 44'd341) / 44'd342);
      5'd19:   recip = 43'((RECIP_BASE + 44'd379) / 44'd380);
      5'd20:   recip = 43'((RECIP_BASE + 44'd419) / 44'd420);
      default: recip = 43'd0;
    endcase
    q_sum = 57'(p_hi) + 57'(p_lo >> 21);
    if (k[0]) begin
      sum_new = sum - $signed({3'b000, div_q});
    end else begin
      sum_new = sum + $signed({3'b000, div_q});
    end
    if (sum_new < 35'sd0) begin
      clamp = 31'd0;
    end else if (sum_new > 35'sd1073741824) begin
      clamp = 31'h4000_0000;
    end else begin
      clamp = sum_new[30:0];
    end
    sp = $signed({1'b0, s_val});
    cp = $signed({1'b0, clamp});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == T_UPD) && (k == SERIES_TERMS) && sel;
      case (state)
        T_IDLE: begin
          if (start) begin
            r     <= 34'(angle);
            q     <= 3'd0;
            state <= T_RED;
          end
        end
        T_RED: begin
          if (r < 34'sd0) begin
            r <= r + TWO_PI_Q28;
          end else if (r >= TWO_PI_Q28) begin
            r <= r - TWO_PI_Q28;
          end else begin
            state <= T_QUAD;
          end
        end
        T_QUAD: begin
          if (r >= HALF_PI_Q28) begin
            r <= r - HALF_PI_Q28;
            q <= q + 3'd1;
          end else begin
            x     <= {r[28:0], 2'b00};
            state <= T_SQM;
          end
        end
        T_SQM: begin
          prod  <= 64'(x) * 64'(x);
          state <= T_SQR;
        end
        T_SQR: begin
          x2    <= rsum[61:30];
          term  <= {1'b0, x};
          sum   <= $signed({4'b0000, x});
          sel   <= 1'b0;
          k     <= 4'd1;
          state <= T_MUL;
        end
        T_MUL: begin
          prod  <= 64'(term) * 64'(x2);
          state <= T_RND;
        end
        T_RND: begin
          div_n <= 34'(rsum[63:30]) + 34'(den >> 1);
          state <= T_DIV;
        end
        T_DIV: begin
          p_lo  <= 55'(div_n) * 55'(recip[20:0]);
          p_hi  <= 56'(div_n) * 56'(recip[42:21]);
          state <= T_QUO;
        end
        T_QUO: begin
          div_q <= q_sum[53:22];
          state <= T_UPD;
        end
        T_UPD: begin
          if ((k == SERIES_TERMS) && !sel) begin
            s_val <= clamp;
            term  <= 32'h4000_0000;
            sum   <= 35'sd1073741824;
            sel   <= 1'b1;
            k     <= 4'd1;
            state <= T_MUL;
          end else if (k == SERIES_TERMS) begin
            state <= T_IDLE;
            case (q[1:0])
              2'd0: begin
                sin_val <= sp;
                cos_val <= cp;
              end
              2'd1: begin
                sin_val <= cp;
                cos_val <= -sp;
              end
              2'd2: begin
                sin_val <= -sp;
                cos_val <= -cp;
              end
              default: begin
                sin_val <= -cp;
                cos_val <= sp;
              end
            endcase
          end else begin
            term  <= div_q;
            sum   <= sum_new;
            k     <= k + 4'd1;
            state <= T_MUL;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/dhfk_back.sv @@
// Back end: builds the link transform and multiplies it into the chain.
`default_nettype none
`include "assert_macros.svh"
module dhfk_back (
  input  wire             clk,
  input  wire             rst,
  input  wire             q_valid,
  output logic            q_take,
  input  dhfk_pkg::work_t q_item,
  input  wire             pop,
  output logic            res_valid,
  output dhfk_pkg::out_t  res
);
  import dhfk_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TA   = 4'd1;
  localparam logic [3:0] S_WA   = 4'd2;
  localparam logic [3:0] S_TT   = 4'd3;
  localparam logic [3:0] S_WT   = 4'd4;
  localparam logic [3:0] S_LMUL = 4'd5;
  localparam logic [3:0] S_LACC = 4'd6;
  localparam logic [3:0] S_PMUL = 4'd7;
  localparam logic [3:0] S_PACC = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]         state;
  work_t              item;
  logic signed [31:0] sa;
  logic signed [31:0] ca;
  logic signed [31:0] st;
  logic signed [31:0] ct;
  logic signed [31:0] link  [0:11];
  logic signed [31:0] chain [0:11];
  logic signed [31:0] nxt   [0:11];
  logic signed [65:0] prod;
  logic signed [37:0] acc;
  logic [2:0]         lidx;
  logic [1:0]         r;
  logic [1:0]         c;
  logic [1:0]         k;

  logic               trig_start;
  logic signed [32:0] trig_angle;
  logic               trig_done;
  logic signed [31:0] trig_sin;
  logic signed [31:0] trig_cos;
  logic signed [32:0] mx;
  logic signed [32:0] my;
  logic signed [35:0] v;
  logic signed [37:0] acc_sum;
  logic signed [37:0] tot;
  logic               commit;

  assign trig_start = (state == S_TA) || (state == S_TT);
  assign trig_angle = (state == S_TA) ? 33'(item.link_twist) : item.joint_angle;
  assign q_take     = (state == S_IDLE) && q_valid;
  assign commit     = (state == S_DONE) && (!res_valid || pop);

  dhfk_trig u_trig (
    .clk     (clk),
    .rst     (rst),
    .start   (trig_start),
    .angle   (trig_angle),
    .done    (trig_done),
    .sin_val (trig_sin),
    .cos_val (trig_cos)
  );

  always_comb begin
    mx = 33'(chain[{r, k}]);
    my = 33'(link[{k, c}]);
    if (state == S_LMUL) begin
      case (lidx)
        3'd0: begin
          mx = 33'(ca);
          my = 33'(st);
        end
        3'd1: begin
          mx = 33'(ca);
          my = 33'(ct);
        end
        3'd2: begin
          mx = 33'(sa);
          my = 33'(st);
        end
        3'd3: begin
          mx = 33'(sa);
          my = 33'(ct);
        end
        3'd4: begin
          mx = 33'(sa);
          my = item.link_offset;
        end
        default: begin
          mx = 33'(ca);
          my = item.link_offset;
        end
      endcase
    end
    v       = round_q30(prod);
    acc_sum = acc + 38'(v);
    tot     = acc_sum + ((c == 2'd3) ? 38'(chain[{r, 2'd3}]) : 38'sd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      for (int i = 0; i < 12; i++) begin
        chain[i] <= (i == 0 || i == 5 || i == 10) ? ONE_Q30 : 32'sd0;
      end
    end else begin
      if (commit) begin
        res_valid <= 1'b1;
      end else if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            item  <= q_item;
            state <= S_TA;
            if (q_item.first_link) begin
              for (int i = 0; i < 12; i++) begin
                chain[i] <= (i == 0 || i == 5 || i == 10) ? ONE_Q30 : 32'sd0;
              end
            end
          end
        end
        S_TA: begin
          state <= S_WA;
        end
        S_WA: begin
          if (trig_done) begin
            sa    <= trig_sin;
            ca    <= trig_cos;
            state <= S_TT;
          end
        end
        S_TT: begin
          state <= S_WT;
        end
        S_WT: begin
          if (trig_done) begin
            st       <= trig_sin;
            ct       <= trig_cos;
            link[0]  <= trig_cos;
            link[1]  <= -trig_sin;
            link[2]  <= 32'sd0;
            link[3]  <= item.link_length;
            link[6]  <= -sa;
            link[10] <= ca;
            lidx     <= 3'd0;
            state    <= S_LMUL;
          end
        end
        S_LMUL: begin
          prod  <= 66'(mx) * 66'(my);
          state <= S_LACC;
        end
        S_LACC: begin
          case (lidx)
            3'd0: link[4] <= sat_word(38'(v));
            3'd1: link[5] <= sat_word(38'(v));
            3'd2: link[8] <= sat_word(38'(v));
            3'd3: link[9] <= sat_word(38'(v));
            3'd4: link[7] <= sat_word(-38'(v));
            default: link[11] <= sat_word(38'(v));
          endcase
          if (lidx == 3'd5) begin
            r     <= 2'd0;
            c     <= 2'd0;
            k     <= 2'd0;
            acc   <= 38'sd0;
            state <= S_PMUL;
          end else begin
            lidx  <= lidx + 3'd1;
            state <= S_LMUL;
          end
        end
        S_PMUL: begin
          prod  <= 66'(mx) * 66'(my);
          state <= S_PACC;
        end
        S_PACC: begin
          if (k == 2'd2) begin
            nxt[{r, c}] <= sat_word(tot);
            acc         <= 38'sd0;
            k           <= 2'd0;
            if (c == 2'd3) begin
              c <= 2'd0;
              if (r == 2'd2) begin
                state <= S_DONE;
              end else begin
                r     <= r + 2'd1;
                state <= S_PMUL;
              end
            end else begin
              c     <= c + 2'd1;
              state <= S_PMUL;
            end
          end else begin
            acc   <= acc_sum;
            k     <= k + 2'd1;
            state <= S_PMUL;
          end
        end
        S_DONE: begin
          if (commit) begin
            for (int i = 0; i < 12; i++) begin
              chain[i] <= nxt[i];
            end
            res <= out_t'({nxt[0], nxt[1], nxt[2], nxt[3], nxt[4], nxt[5],
                           nxt[6], nxt[7], nxt[8], nxt[9], nxt[10], nxt[11]});
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMP(a_trig_done_expected, trig_done, (state == S_WA) || (state == S_WT))
  `ASSERT_NXT(a_commit_fills_output, (state == S_DONE) && !res_valid, res_valid)
  `ASSERT_NXT(a_result_held, res_valid && !pop, res_valid && $stable(res))
  `ASSERT_NXT(a_idle_without_work, (state == S_IDLE) && !q_valid, state == S_IDLE)

endmodule
`default_nettype wire

@@ hdl/dh_forward_kinematics_chain_unit.sv @@
// Top level of the Denavit-Hartenberg forward kinematics chain unit.
//
//   Channel   Handshake       Payload
//   input     push / full     link_item (one link of the chain)
//   result    pop / empty     pose (top three rows of the chain transform)
//
// A request accepted by the back end goes through two sine and cosine evaluations,
// each summing twenty series terms, then the link entries and the chain product.
// The front queue holds two links, so requests are taken while a link is being
// worked on. rst is synchronous and loads the identity transform. A result waiting
// in the output register stalls only the final commit.
`default_nettype none
module dh_forward_kinematics_chain_unit (
  input  wire            clk,
  input  wire            rst,
  input  wire            push,
  output logic           full,
  input  dhfk_pkg::in_t  link_item,
  input  wire            pop,
  output logic           empty,
  output dhfk_pkg::out_t pose
);
  import dhfk_pkg::*;

  logic  q_valid;
  logic  q_take;
  work_t q_item;
  logic  res_valid;

  dhfk_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .link_item (link_item),
    .q_valid   (q_valid),
    .q_take    (q_take),
    .q_item    (q_item)
  );

  dhfk_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_take    (q_take),
    .q_item    (q_item),
    .pop       (pop),
    .res_valid (res_valid),
    .res       (pose)
  );

  assign empty = !res_valid;

endmodule
`default_nettype wire
